@@ hdl/dpdc_pkg.sv @@
// Shared types and constants for the distance PI drive controller.
package dpdc_pkg;

  localparam int MeasW   = 13;
  localparam int TolW    = 8;
  localparam int GainW   = 16;
  localparam int LimW    = 12;
  localparam int SpdMagW = 7;
  localparam int IntegW  = 13;
  localparam int ErrW    = MeasW + 1;
  localparam int ProdW   = GainW + 1 + ErrW;
  localparam int SumW    = ProdW + 1;
  localparam int SpeedW  = 8;
  localparam int MagShift = 12;

  localparam int AddrW   = 5;
  localparam int DataW   = 32;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_TOL    = 3'd1,
    REG_PGAIN  = 3'd2,
    REG_IGAIN  = 3'd3,
    REG_ILIMIT = 3'd4,
    REG_FLOOR  = 3'd5,
    REG_CEIL   = 3'd6
  } reg_idx_e;

  localparam logic [MeasW-1:0]   TargetRst = 13'd288;
  localparam logic [TolW-1:0]    TolRst    = 8'd8;
  localparam logic [GainW-1:0]   PGainRst  = 16'd1024;
  localparam logic [GainW-1:0]   IGainRst  = 16'd26;
  localparam logic [LimW-1:0]    ILimitRst = 12'd160;
  localparam logic [SpdMagW-1:0] FloorRst  = 7'd15;
  localparam logic [SpdMagW-1:0] CeilRst   = 7'd40;

  typedef struct packed {
    logic [MeasW-1:0]   target;
    logic [TolW-1:0]    tol;
    logic [GainW-1:0]   pgain;
    logic [GainW-1:0]   igain;
    logic [LimW-1:0]    ilimit;
    logic [SpdMagW-1:0] floor_spd;
    logic [SpdMagW-1:0] ceil_spd;
  } cfg_t;

  // error stage -> gain stage
  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [IntegW-1:0] integ;
    logic                     drive;
    logic                     at;
  } ctl_t;

  // gain stage -> output stage
  typedef struct packed {
    logic signed [ProdW-1:0] p_term;
    logic signed [ProdW-1:0] i_term;
    logic                    pos;
    logic                    drive;
    logic                    at;
  } prod_t;

endpackage

@@ hdl/dpdc_regs.sv @@
// APB configuration register file.
module dpdc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpdc_pkg::AddrW-1:0]  paddr,
  input  logic [dpdc_pkg::DataW-1:0]  pwdata,
  output logic [dpdc_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output dpdc_pkg::cfg_t              cfg_o
);

  dpdc_pkg::cfg_t   cfg_q;
  dpdc_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = dpdc_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= dpdc_pkg::TargetRst;
      cfg_q.tol       <= dpdc_pkg::TolRst;
      cfg_q.pgain     <= dpdc_pkg::PGainRst;
      cfg_q.igain     <= dpdc_pkg::IGainRst;
      cfg_q.ilimit    <= dpdc_pkg::ILimitRst;
      cfg_q.floor_spd <= dpdc_pkg::FloorRst;
      cfg_q.ceil_spd  <= dpdc_pkg::CeilRst;
    end else if (wr_en) begin
      unique case (idx)
        dpdc_pkg::REG_TARGET: cfg_q.target    <= pwdata[dpdc_pkg::MeasW-1:0];
        dpdc_pkg::REG_TOL:    cfg_q.tol       <= pwdata[dpdc_pkg::TolW-1:0];
        dpdc_pkg::REG_PGAIN:  cfg_q.pgain     <= pwdata[dpdc_pkg::GainW-1:0];
        dpdc_pkg::REG_IGAIN:  cfg_q.igain     <= pwdata[dpdc_pkg::GainW-1:0];
        dpdc_pkg::REG_ILIMIT: cfg_q.ilimit    <= pwdata[dpdc_pkg::LimW-1:0];
        dpdc_pkg::REG_FLOOR:  cfg_q.floor_spd <= pwdata[dpdc_pkg::SpdMagW-1:0];
        dpdc_pkg::REG_CEIL:   cfg_q.ceil_spd  <= pwdata[dpdc_pkg::SpdMagW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dpdc_pkg::REG_TARGET: prdata = {19'd0, cfg_q.target};
      dpdc_pkg::REG_TOL:    prdata = {24'd0, cfg_q.tol};
      dpdc_pkg::REG_PGAIN:  prdata = {16'd0, cfg_q.pgain};
      dpdc_pkg::REG_IGAIN:  prdata = {16'd0, cfg_q.igain};
      dpdc_pkg::REG_ILIMIT: prdata = {20'd0, cfg_q.ilimit};
      dpdc_pkg::REG_FLOOR:  prdata = {25'd0, cfg_q.floor_spd};
      dpdc_pkg::REG_CEIL:   prdata = {25'd0, cfg_q.ceil_spd};
      default:              prdata = '0;
    endcase
  end

endmodule

@@ hdl/dpdc_err.sv @@
// Error stage: tolerance check, integral update with clamp, at-target latch.
module dpdc_err (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpdc_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dpdc_pkg::MeasW-1:0]  meas_i,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dpdc_pkg::ctl_t              out_o,
  output logic                        reached_o
);

  localparam int WideW = dpdc_pkg::ErrW + 1;

  logic                                   valid_q;
  dpdc_pkg::ctl_t                         ctl_q, ctl_d;
  logic signed [dpdc_pkg::IntegW-1:0]     integ_q, integ_d;
  logic                                   reached_q, reached_d;
  logic signed [dpdc_pkg::IntegW-1:0]     integ_base;
  logic                                   reached_base;
  logic signed [dpdc_pkg::ErrW-1:0]       err;
  logic [dpdc_pkg::ErrW-1:0]              aerr;
  logic                                   in_band;
  logic signed [WideW-1:0]                sum_w, lim_w;
  logic                                   accept;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_o       = ctl_q;
  assign reached_o   = reached_q;

  assign integ_base   = restart_i ? '0 : integ_q;
  assign reached_base = restart_i ? 1'b0 : reached_q;

  assign err     = $signed({1'b0, meas_i}) - $signed({1'b0, cfg_i.target});
  assign aerr    = err[dpdc_pkg::ErrW-1] ? dpdc_pkg::ErrW'(-err) : dpdc_pkg::ErrW'(err);
  assign in_band = aerr <= {{(dpdc_pkg::ErrW-dpdc_pkg::TolW){1'b0}}, cfg_i.tol};
  assign sum_w   = WideW'(integ_base) + WideW'(err);
  assign lim_w   = $signed({{(WideW-dpdc_pkg::LimW){1'b0}}, cfg_i.ilimit});

  always_comb begin
    integ_d   = integ_base;
    reached_d = reached_base;
    ctl_d.err   = err;
    ctl_d.drive = 1'b0;
    if (!reached_base) begin
      if (in_band) begin
        reached_d = 1'b1;
      end else begin
        // anti-windup clamp to +/- limit
        priority if (sum_w < -lim_w) begin
          integ_d = dpdc_pkg::IntegW'(-lim_w);
        end else if (sum_w > lim_w) begin
          integ_d = dpdc_pkg::IntegW'(lim_w);
        end else begin
          integ_d = dpdc_pkg::IntegW'(sum_w);
        end
        ctl_d.drive = 1'b1;
      end
    end
    ctl_d.integ = integ_d;
    ctl_d.at    = reached_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      integ_q   <= '0;
      reached_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        integ_q   <= integ_d;
        reached_q <= reached_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl_q <= ctl_d;
    end
  end

endmodule

@@ hdl/dpdc_gain.sv @@
// Gain stage: proportional and integral products, registered.
module dpdc_gain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpdc_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dpdc_pkg::ctl_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dpdc_pkg::prod_t out_o
);

  logic                                 valid_q;
  dpdc_pkg::prod_t                      prod_q, prod_d;
  logic signed [dpdc_pkg::GainW:0]      pg_s, ig_s;
  logic                                 accept;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_o       = prod_q;

  assign pg_s = $signed({1'b0, cfg_i.pgain});
  assign ig_s = $signed({1'b0, cfg_i.igain});

  always_comb begin
    prod_d.p_term = dpdc_pkg::ProdW'(pg_s * in_i.err);
    prod_d.i_term = dpdc_pkg::ProdW'(ig_s * in_i.integ);
    prod_d.pos    = !in_i.err[dpdc_pkg::ErrW-1];
    prod_d.drive  = in_i.drive;
    prod_d.at     = in_i.at;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
    end
  end

endmodule

@@ hdl/dpdc_out.sv @@
// Output stage: sum, magnitude, shift, speed clamp, sign; result register.
module dpdc_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dpdc_pkg::cfg_t                      cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dpdc_pkg::prod_t                     in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dpdc_pkg::SpeedW-1:0]  speed_o,
  output logic                                at_o
);

  localparam int ShW = dpdc_pkg::SumW - dpdc_pkg::MagShift;

  logic                                 valid_q;
  logic signed [dpdc_pkg::SpeedW-1:0]   speed_q, speed_d;
  logic                                 at_q;
  logic signed [dpdc_pkg::SumW-1:0]     sum;
  logic [dpdc_pkg::SumW-1:0]            mag;
  logic [ShW-1:0]                       sh;
  logic [dpdc_pkg::SpdMagW-1:0]         m;
  logic                                 accept;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign speed_o     = speed_q;
  assign at_o        = at_q;

  assign sum = dpdc_pkg::SumW'(in_i.p_term) + dpdc_pkg::SumW'(in_i.i_term);
  assign mag = sum[dpdc_pkg::SumW-1] ? dpdc_pkg::SumW'(-sum) : dpdc_pkg::SumW'(sum);
  assign sh  = mag[dpdc_pkg::SumW-1:dpdc_pkg::MagShift];

  always_comb begin
    // floor is checked first: when they cross, below-floor gets floor, else ceiling
    priority if (sh < ShW'(cfg_i.floor_spd)) begin
      m = cfg_i.floor_spd;
    end else if (sh > ShW'(cfg_i.ceil_spd)) begin
      m = cfg_i.ceil_spd;
    end else begin
      m = sh[dpdc_pkg::SpdMagW-1:0];
    end
    if (!in_i.drive) begin
      speed_d = '0;
    end else if (in_i.pos) begin
      speed_d = $signed({1'b0, m});
    end else begin
      speed_d = -$signed({1'b0, m});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      speed_q <= speed_d;
      at_q    <= in_i.at;
    end
  end

endmodule

@@ hdl/distance_pi_drive_controller.sv @@
// Distance PI drive controller top level: APB config, three-stage stream pipeline.
//
//  Port group   Direction  Contents
//  s_axis_*     in         tdata[12:0] measured_distance, tuser restart
//  m_axis_*     out        tdata[7:0] drive_speed (signed), tuser at_target
//  APB          in/out     7 registers at byte address 4*index, pready tied high
//
//  Throughput is one transaction per cycle unless the output stalls; the stages are
//  error/integral stage, gain multiply stage and clamp/output stage, each registered.
//  The integral and at-target flag update in the error stage at input accept,
//  so consecutive samples see each other's state with no hazard.
//  Each stage has its own valid bit; a stalled output fills the bubbles first.
//  Reset clears the valid bits, the integral and the flag, and loads the config defaults.
module distance_pi_drive_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [12:0] measured_distance
  input  logic                        s_axis_tuser,  // [0] restart
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [7:0] drive_speed
  output logic                        m_axis_tuser,  // [0] at_target
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpdc_pkg::AddrW-1:0]  paddr,
  input  logic [dpdc_pkg::DataW-1:0]  pwdata,
  output logic [dpdc_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  dpdc_pkg::cfg_t                       cfg;
  dpdc_pkg::ctl_t                       ctl;
  dpdc_pkg::prod_t                      prod;
  logic                                 v1, r1, v2, r2;
  logic                                 reached;
  logic signed [dpdc_pkg::SpeedW-1:0]   speed;
  logic                                 at;

  dpdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dpdc_err u_err (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .meas_i      (s_axis_tdata[dpdc_pkg::MeasW-1:0]),
    .restart_i   (s_axis_tuser),
    .out_valid_o (v1),
    .out_ready_i (r1),
    .out_o       (ctl),
    .reached_o   (reached)
  );

  dpdc_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (v1),
    .in_ready_o  (r1),
    .in_i        (ctl),
    .out_valid_o (v2),
    .out_ready_i (r2),
    .out_o       (prod)
  );

  dpdc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (v2),
    .in_ready_o  (r2),
    .in_i        (prod),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .speed_o     (speed),
    .at_o        (at)
  );

  assign m_axis_tdata = speed;
  assign m_axis_tuser = at;

  // at target always means stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && at) |-> (speed == '0))
    else $error("nonzero speed with at_target set");

  // an accepted transaction always lands in the error stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted transaction lost at error stage");

  // the flag only sets on an accepted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(reached) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("at-target flag set without a sample");

endmodule
